// ----- rtl/core/packet_rate_interval_binner_macros.svh -----
// assertion macros for the packet rate interval binner checker
// no dependencies; included by files that hold concurrent assertions
`ifndef PACKET_RATE_INTERVAL_BINNER_MACROS_SVH
`define PACKET_RATE_INTERVAL_BINNER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRIB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prib assertion failed");

// next-cycle implication, disabled during reset
`define PRIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prib assertion failed");

`endif

// ----- rtl/core/prib_pkg.sv -----
// types and constants for the packet rate interval binner
// no dependencies; imported by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package prib_pkg;

  // field widths
  localparam int TIME_BITS = 56;
  localparam int BE_W      = TIME_BITS + 2;
  localparam int CNT_W     = $clog2(TIME_BITS);
  localparam int SIZE_W    = 16;
  localparam int PKT_W     = 32;
  localparam int BYTE_W    = 48;
  localparam int EMPTY_W   = 32;
  localparam int IV_W      = 32;

  // configuration port
  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_INTERVAL = 2'd0;
  localparam logic [IV_W-1:0] INTERVAL_RESET = 32'd100000;

  typedef struct packed {
    logic [TIME_BITS-1:0] timestamp;
    logic [SIZE_W-1:0]    packet_size;
  } in_item_t;

  typedef struct packed {
    logic [PKT_W-1:0]   bin_packets;
    logic [BYTE_W-1:0]  bin_bytes;
    logic [EMPTY_W-1:0] empty_bins_after;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/packet_rate_interval_binner.sv -----
// a packet inside the open bin is counted in place and in_ready stays high (1 item/cycle)
// a packet that closes the bin starts the gap division: one quotient bit per cycle
//   from the restoring subtract/compare divider in S_DIV, then S_EMIT loads the output once it is free
// the result waits in an output register; the next packet is taken once it is loaded
// reset (synchronous, rst_n low): no bin open, interval_length = 100000, output empty
// top level of the packet rate interval binner; depends on prib_pkg
`timescale 1ns / 1ps
`default_nettype none

module packet_rate_interval_binner (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire prib_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output prib_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prib_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import prib_pkg::*;

  state_t               state_r, state_nxt;
  logic [IV_W-1:0]      interval_r, interval_nxt;
  logic                 started_r, started_nxt;
  logic [BE_W-1:0]      bin_end_r, bin_end_nxt;
  logic [PKT_W-1:0]     pkt_r, pkt_nxt;
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [TIME_BITS-1:0] quo_r, quo_nxt;
  logic [IV_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] t_r, t_nxt;
  logic [IV_W-1:0]      iv_r, iv_nxt;
  logic [PKT_W-1:0]     pend_pkts_r, pend_pkts_nxt;
  logic [BYTE_W-1:0]    pend_bytes_r, pend_bytes_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 accept;
  logic                 cfg_wr;
  logic [IV_W-1:0]      iv_eff;
  logic                 in_bin;
  logic [BYTE_W:0]      byte_sum;
  logic [IV_W:0]        rem_sh;
  logic                 rem_ge;
  logic [63:0]          quo_wide;
  logic [EMPTY_W-1:0]   empty_sat;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr == ADDR_INTERVAL) ? interval_r : 32'd0;
  assign cfg_wr    = psel & penable & pwrite & pready & (paddr == ADDR_INTERVAL);

  // zero interval acts as one
  assign iv_eff = (interval_r == '0) ? {{(IV_W-1){1'b0}}, 1'b1} : interval_r;

  // open bin hit and saturating byte add
  assign in_bin   = {2'b00, in_data.timestamp} < bin_end_r;
  assign byte_sum = {1'b0, byte_r} + (BYTE_W+1)'(in_data.packet_size);

  // one restoring divider step
  assign rem_sh = {rem_r, quo_r[TIME_BITS-1]};
  assign rem_ge = rem_sh >= {1'b0, iv_r};

  // empty bin count saturates at 32 bits
  assign quo_wide  = 64'(quo_r);
  assign empty_sat = (|quo_wide[63:32]) ? '1 : quo_wide[EMPTY_W-1:0];

  // sequencer and datapath
  always_comb begin
    state_nxt      = state_r;
    interval_nxt   = interval_r;
    started_nxt    = started_r;
    bin_end_nxt    = bin_end_r;
    pkt_nxt        = pkt_r;
    byte_nxt       = byte_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    t_nxt          = t_r;
    iv_nxt         = iv_r;
    pend_pkts_nxt  = pend_pkts_r;
    pend_bytes_nxt = pend_bytes_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_wr) begin
      interval_nxt = pwdata;
    end

    // output transfer frees the register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!started_r) begin
            // first packet opens the first bin
            started_nxt = 1'b1;
            bin_end_nxt = BE_W'(in_data.timestamp) + BE_W'(iv_eff);
            pkt_nxt     = {{(PKT_W-1){1'b0}}, 1'b1};
            byte_nxt    = BYTE_W'(in_data.packet_size);
          end else if (in_bin) begin
            // count in the open bin, saturating
            if (pkt_r != '1) begin
              pkt_nxt = pkt_r + 1'b1;
            end
            byte_nxt = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
          end else begin
            // close the bin and start the gap division
            pend_pkts_nxt  = pkt_r;
            pend_bytes_nxt = byte_r;
            pkt_nxt        = {{(PKT_W-1){1'b0}}, 1'b1};
            byte_nxt       = BYTE_W'(in_data.packet_size);
            t_nxt          = in_data.timestamp;
            iv_nxt         = iv_eff;
            quo_nxt        = in_data.timestamp - bin_end_r[TIME_BITS-1:0];
            rem_nxt        = '0;
            cnt_nxt        = CNT_W'(TIME_BITS - 1);
            state_nxt      = S_DIV;
          end
        end
      end
      S_DIV: begin
        quo_nxt = {quo_r[TIME_BITS-2:0], rem_ge};
        rem_nxt = rem_ge ? IV_W'(rem_sh - {1'b0, iv_r}) : rem_sh[IV_W-1:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // new end is t - remainder + interval
        bin_end_nxt = BE_W'(t_r) + BE_W'(iv_r) - BE_W'(rem_r);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.bin_packets      = pend_pkts_r;
          out_data_nxt.bin_bytes        = pend_bytes_r;
          out_data_nxt.empty_bins_after = empty_sat;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= INTERVAL_RESET;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      interval_r  <= interval_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    bin_end_r    <= bin_end_nxt;
    pkt_r        <= pkt_nxt;
    byte_r       <= byte_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    t_r          <= t_nxt;
    iv_r         <= iv_nxt;
    pend_pkts_r  <= pend_pkts_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/prib_checker.sv -----
// port-level assertions for the packet rate interval binner, bound to the top level
// depends on prib_pkg and packet_rate_interval_binner_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "packet_rate_interval_binner_macros.svh"

module prib_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire prib_pkg::out_item_t out_data,
  input wire logic                pready
);
  import prib_pkg::*;

  // a stalled result holds
  `PRIB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // a result shows up only right after the input side was blocked
  `PRIB_ASSERT_IMPL(a_out_after_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // a closed bin always holds at least its opening packet
  `PRIB_ASSERT_IMPL(a_bin_nonempty, clk, rst_n, out_valid, out_data.bin_packets != '0)

  // the configuration port never waits
  `PRIB_ASSERT_IMPL(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind packet_rate_interval_binner prib_checker u_prib_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);

`default_nettype wire

// ----- bench/packet_rate_interval_binner_test.sv -----
// self-checking bench for packet_rate_interval_binner: directed table, then random phases
// predicts closed-bin results in-line and checks each output transfer; depends on prib_pkg
`timescale 1ns / 1ps

module packet_rate_interval_binner_test;
  import prib_pkg::*;

  localparam int          PLAN_ROWS      = 17;
  localparam int          PHASES         = 8;
  localparam int          PHASE_ITEMS    = 130;
  localparam int          JUMP_PHASE     = 5;
  localparam int          DRAIN_CYCLES   = 64;
  localparam int          TAIL_CYCLES    = 64;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [63:0] STAMP_MAX      = (64'd1 << TIME_BITS) - 1;

  typedef enum logic {ROW_PACKET, ROW_INTERVAL} row_kind_t;

  // value is the timestamp of a packet row or the interval of a register row
  typedef struct {
    row_kind_t   kind;
    logic [63:0] value;
    logic [15:0] size;
    bit          typed;
    logic [31:0] pk;
    logic [47:0] by;
    logic [31:0] em;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // bin model state
  bit          run_open;
  logic [63:0] close_time;
  logic [31:0] open_packets;
  logic [47:0] open_bytes;
  logic [31:0] interval_reg;
  logic [63:0] last_stamp;

  out_item_t bins_due[$];
  int        mismatches;
  int        quiet_cycles;
  bit        full_rate;

  // directed rows: boundaries, gap walk, decreasing times, zero and widest interval,
  // empty-bin count saturation
  row_t plan [PLAN_ROWS] = '{
    '{ROW_PACKET,   64'd0,             16'd0,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd99999,         16'hFFFF,  1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd100000,        16'd1,     1'b1, 32'd2, 48'd65535, 32'd0},
    '{ROW_PACKET,   64'd100000,        16'd5,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd50,            16'd7,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd450000,        16'd0,     1'b1, 32'd3, 48'd13,    32'd2},
    '{ROW_INTERVAL, 64'd0,             16'd0,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd500000,        16'd2,     1'b1, 32'd1, 48'd0,     32'd0},
    '{ROW_PACKET,   64'd500001,        16'd3,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h1_0007_A127,   16'hFFFF,  1'b1, 32'd1, 48'd3,     32'hFFFF_FFFF},
    '{ROW_INTERVAL, 64'hFFFF_FFFF,     16'd0,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h1_0007_A127,   16'd1,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h1_0007_A128,   16'd4,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h4_0007_A125,   16'd9,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_INTERVAL, 64'd1,             16'd0,     1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h5_0007_A124,   16'hFFFF,  1'b0, 32'd0, 48'd0,     32'd0},
    '{ROW_PACKET,   64'h5_0007_A124,   16'd0,     1'b0, 32'd0, 48'd0,     32'd0}
  };

  packet_rate_interval_binner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // add one packet to the open bin, both totals saturate
  function automatic void tally(input logic [15:0] size);
    logic [48:0] sum;
    if (open_packets != 32'hFFFF_FFFF) open_packets = open_packets + 1;
    sum = {1'b0, open_bytes} + 49'(size);
    open_bytes = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
  endfunction

  // returns 1 when this packet closes the open bin, with the closed bin in res
  function automatic bit bin_packet(input in_item_t pkt, output out_item_t res);
    logic [63:0] stamp;
    logic [63:0] iv;
    logic [63:0] skipped;
    stamp = 64'(pkt.timestamp);
    iv = (interval_reg == 32'd0) ? 64'd1 : 64'(interval_reg);
    res = '0;
    if (!run_open) begin
      run_open = 1'b1;
      close_time = stamp + iv;
      open_packets = '0;
      open_bytes = '0;
      tally(pkt.packet_size);
      return 1'b0;
    end
    if (stamp < close_time) begin
      tally(pkt.packet_size);
      return 1'b0;
    end
    // whole empty intervals between the old bin end and this packet
    skipped = (stamp - close_time) / iv;
    res.bin_packets = open_packets;
    res.bin_bytes = open_bytes;
    res.empty_bins_after = (skipped > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : skipped[31:0];
    close_time = close_time + skipped * iv + iv;
    open_packets = '0;
    open_bytes = '0;
    tally(pkt.packet_size);
    return 1'b1;
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_packet(input in_item_t pkt, input bit typed, input out_item_t typed_bin);
    out_item_t res;
    if (!full_rate && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = pkt;
    do @(posedge clk); while (!in_ready);
    if (bin_packet(pkt, res)) bins_due.push_back(typed ? typed_bin : res);
    if (64'(pkt.timestamp) > last_stamp) last_stamp = 64'(pkt.timestamp);
    @(negedge clk);
  endtask

  task automatic read_interval(input logic [31:0] want);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = ADDR_INTERVAL;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("interval_length: expected %0d, got %0d", want, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // register writes only once the block has gone idle
  task automatic write_interval(input logic [31:0] value);
    in_valid = 1'b0;
    while (bins_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_INTERVAL;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    interval_reg = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    read_interval(value);
  endtask

  // stimulus: directed table, then random phases at varied intervals
  initial begin : stimulus
    in_item_t    pkt;
    out_item_t   typed_bin;
    logic [63:0] iv;
    logic [63:0] span;
    logic [63:0] stamp;
    int unsigned roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    full_rate = 1'b0;
    mismatches = 0;
    run_open = 1'b0;
    close_time = '0;
    open_packets = '0;
    open_bytes = '0;
    interval_reg = INTERVAL_RESET;
    last_stamp = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    read_interval(INTERVAL_RESET);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_INTERVAL) begin
        write_interval(plan[i].value[31:0]);
      end else begin
        pkt.timestamp = plan[i].value[TIME_BITS-1:0];
        pkt.packet_size = plan[i].size;
        typed_bin.bin_packets = plan[i].pk;
        typed_bin.bin_bytes = plan[i].by;
        typed_bin.empty_bins_after = plan[i].em;
        send_packet(pkt, plan[i].typed, typed_bin);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_interval(32'd1);
        1: write_interval(32'd0);
        2: write_interval(32'hFFFF_FFFF);
        3: write_interval(INTERVAL_RESET);
        4: write_interval($urandom_range(2, 64));
        5: write_interval($urandom);
        6: write_interval($urandom_range(2, 5000));
        default: write_interval($urandom_range(1, 200));
      endcase
      full_rate = (phase == PHASES - 1);
      iv = (interval_reg == 32'd0) ? 64'd1 : 64'(interval_reg);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          // inside the open bin
          span = close_time - last_stamp;
          if (span == 0) span = 1;
          stamp = last_stamp + ({$urandom, $urandom} % span);
        end else if (roll < 58) begin
          stamp = close_time;
        end else if (roll < 85) begin
          // next bin or a short gap
          stamp = close_time + 64'($urandom_range(0, 3)) * iv + ({$urandom, $urandom} % iv);
        end else if (roll < 93) begin
          stamp = close_time + ({$urandom, $urandom} % (64'd1 << $urandom_range(33, 40)));
        end else begin
          // out of order, lands in the open bin
          stamp = {$urandom, $urandom} % (last_stamp + 1);
        end
        if (phase == JUMP_PHASE && n == 0)
          stamp = {8'd0, 1'b1, 15'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
        if (stamp > STAMP_MAX) stamp = STAMP_MAX;
        roll = $urandom_range(0, 9);
        pkt.packet_size = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom);
        pkt.timestamp = stamp[TIME_BITS-1:0];
        // the very last packet sits at the top of the time range
        if (phase == PHASES - 1 && n == PHASE_ITEMS - 1) begin
          pkt.timestamp = '1;
          pkt.packet_size = 16'hFFFF;
        end
        send_packet(pkt, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && bins_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result side back-pressure in short bursts
  initial begin : result_sink
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else if (!full_rate && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare each output transfer with the oldest predicted bin
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        $error("bin result with none predicted: packets %0d bytes %0d empty %0d",
               out_data.bin_packets, out_data.bin_bytes, out_data.empty_bins_after);
        mismatches++;
      end else begin
        want = bins_due.pop_front();
        if (out_data.bin_packets !== want.bin_packets) begin
          $error("bin_packets: expected %0d, got %0d", want.bin_packets, out_data.bin_packets);
          mismatches++;
        end
        if (out_data.bin_bytes !== want.bin_bytes) begin
          $error("bin_bytes: expected %0d, got %0d", want.bin_bytes, out_data.bin_bytes);
          mismatches++;
        end
        if (out_data.empty_bins_after !== want.empty_bins_after) begin
          $error("empty_bins_after: expected %0d, got %0d",
                 want.empty_bins_after, out_data.empty_bins_after);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
